/* hw/rtl/relay_permission_table_core_macros.svh */
// Assertion macros shared by the relay permission table RTL.
`ifndef RELAY_PERMISSION_TABLE_CORE_MACROS_SVH
`define RELAY_PERMISSION_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define RPT_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define RPT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RPT_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define RPT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* hw/rtl/rpt_pkg.sv */
// Types and constants shared by the relay permission table and its cells.
package rpt_pkg;

   typedef enum logic [2:0] {
      FUNC_TICK         = 3'd0,
      FUNC_ADD          = 3'd1,
      FUNC_REMOVE       = 3'd2,
      FUNC_REMOVE_ALL   = 3'd3,
      FUNC_LOOKUP       = 3'd4,
      FUNC_USAGE        = 3'd5,
      FUNC_SET_LIFETIME = 3'd6,
      FUNC_SWEEP        = 3'd7
   } func_type;

   localparam logic [31:0] UNLIMITED_BW = 32'd99999999;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic        look;
      logic        apply;
      func_type    func;
      logic [31:0] peer_ip;
      logic [31:0] now;
      logic [15:0] perm_life;
      logic        any_match;
   } rpt_cmd_type;

   // Handed from each cell to the next one up the chain.
   typedef struct packed {
      logic match_seen;
      logic free_seen;
   } rpt_link_type;

   // Per-cell status seen by the controller.
   typedef struct packed {
      logic valid;
      logic match;
      logic drop;
   } rpt_cell_status_type;

endpackage

/* hw/rtl/rpt_cell.sv */
// One permission slot: peer address, refresh stamp and valid bit.
module rpt_cell
   import rpt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  rpt_cmd_type         cmd,
   input  rpt_link_type        link_in,
   output rpt_link_type        link_out,
   output rpt_cell_status_type status
);

   logic        valid_ff, valid_in;
   logic [31:0] peer_ff, peer_in;
   logic [31:0] stamp_ff, stamp_in;
   logic        match_ff, match_in;
   logic        claim_ff, claim_in;
   logic        drop_ff, drop_in;

   logic        hit_now;
   logic [31:0] age;
   logic        expired;

   assign hit_now = valid_ff && (peer_ff == cmd.peer_ip);
   assign age     = cmd.now - stamp_ff;
   assign expired = valid_ff && (age >= {16'b0, cmd.perm_life});

   assign link_out.match_seen = link_in.match_seen | hit_now;
   assign link_out.free_seen  = link_in.free_seen | !valid_ff;

   assign status.valid = valid_ff;
   assign status.match = match_ff;
   assign status.drop  = drop_ff;

   always_comb begin
      valid_in = valid_ff;
      peer_in  = peer_ff;
      stamp_in = stamp_ff;
      match_in = match_ff;
      claim_in = claim_ff;
      drop_in  = drop_ff;
      if (cmd.look) begin
         match_in = hit_now;
         // lowest free slot: no free slot below this one
         claim_in = !valid_ff && !link_in.free_seen;
         drop_in  = expired;
      end
      if (cmd.apply) begin
         case (cmd.func)
            FUNC_ADD: begin
               if (match_ff) begin
                  stamp_in = cmd.now;
               end else if (!cmd.any_match && claim_ff) begin
                  valid_in = 1'b1;
                  peer_in  = cmd.peer_ip;
                  stamp_in = cmd.now;
               end
            end
            FUNC_REMOVE: begin
               if (match_ff) valid_in = 1'b0;
            end
            FUNC_REMOVE_ALL: begin
               valid_in = 1'b0;
            end
            FUNC_SWEEP: begin
               if (drop_ff) valid_in = 1'b0;
            end
            default: begin
               valid_in = valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
         claim_ff <= 1'b0;
         drop_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
         claim_ff <= claim_in;
         drop_ff  <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      peer_ff  <= peer_in;
      stamp_ff <= stamp_in;
   end

endmodule

/* hw/rtl/relay_permission_table_core.sv */
// Top level of the relay permission table: controller, cell chain and ports.
// Relay permission table with allocation lifetime and bandwidth accounting. Every
// request transaction (func in req_tuser, peer address and value in req_tdata)
// yields one response transaction carrying the outcome and the allocation status
// after the operation. A transaction steps through the states in order: the
// accept cycle, a lookup cycle in which each cell compares its peer address and
// the free-slot and match flags ripple up the cell chain, an update cycle in which
// the cells and the counters change, and a status cycle that subtracts remaining
// time and bandwidth and loads the response register. req_tready is high only
// between transactions; the status cycle holds while a previous response waits.
// Registers: 0x0 bandwidth_limit (0 = unlimited), 0x4 permission_lifetime.
`include "relay_permission_table_core_macros.svh"
module relay_permission_table_core
   import rpt_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // peer_ip[31:0], value[63:32]
   input  logic [2:0]  req_tuser,   // func[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // hit[0], table_full[1], removed_count[6:2], entry_count[11:7],
   // time_remaining[43:12], bandwidth_remaining[75:44], alloc_expired[76],
   // alloc_ok[77], zero[79:78]
   output logic [79:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOOK   = 4'b0010,
      ST_APPLY  = 4'b0100,
      ST_REPORT = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   func_type           func_ff, func_in;
   logic [31:0]        ip_ff, ip_in;
   logic [31:0]        value_ff, value_in;
   logic [31:0]        now_ff, now_in;
   logic [31:0]        elapsed_ff, elapsed_in;
   logic [31:0]        life_ff, life_in;
   logic [31:0]        used_ff, used_in;
   logic [CNT_W-1:0]   entry_ff, entry_in;
   logic               any_match_ff, any_match_in;
   logic               any_free_ff, any_free_in;
   logic               hit_ff, hit_in;
   logic               full_ff, full_in;
   logic [CNT_W-1:0]   removed_ff, removed_in;
   logic [31:0]        limit_ff, limit_in;
   logic [15:0]        perm_life_ff, perm_life_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [79:0]        rsp_data_ff, rsp_data_in;

   rpt_cmd_type         cmd;
   rpt_link_type        links [ENTRIES+1];
   rpt_cell_status_type cell_status [ENTRIES];
   logic [ENTRIES-1:0]  valid_vec;
   logic [ENTRIES-1:0]  match_vec;
   logic [ENTRIES-1:0]  drop_vec;

   logic               csr_wr;
   logic [CNT_W-1:0]   drop_count;
   logic [32:0]        used_sum;
   logic [32:0]        time_diff;
   logic [32:0]        bw_diff;
   logic [31:0]        trem;
   logic [31:0]        brem;
   logic               rsp_free;
   logic [CNT_W+4:0]   removed_wide;
   logic [CNT_W+4:0]   entry_wide;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = csr_paddr[2] ? {16'b0, perm_life_ff} : limit_ff;

   always_comb begin
      limit_in     = limit_ff;
      perm_life_in = perm_life_ff;
      if (csr_wr) begin
         if (csr_paddr[2]) perm_life_in = csr_pwdata[15:0];
         else              limit_in     = csr_pwdata;
      end
   end

   // ---------------- cell chain ----------------
   assign cmd.look      = (state_ff == ST_LOOK);
   assign cmd.apply     = (state_ff == ST_APPLY);
   assign cmd.func      = func_ff;
   assign cmd.peer_ip   = ip_ff;
   assign cmd.now       = now_ff;
   assign cmd.perm_life = perm_life_ff;
   assign cmd.any_match = any_match_ff;

   assign links[0] = '0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      rpt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .link_in  (links[g]),
         .link_out (links[g+1]),
         .status   (cell_status[g])
      );
      assign valid_vec[g] = cell_status[g].valid;
      assign match_vec[g] = cell_status[g].match;
      assign drop_vec[g]  = cell_status[g].drop;
   end

   always_comb begin
      drop_count = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         drop_count = drop_count + CNT_W'(drop_vec[i]);
      end
   end

   // ---------------- status arithmetic ----------------
   assign used_sum  = {1'b0, used_ff} + {1'b0, value_ff};
   assign time_diff = {1'b0, life_ff} - {1'b0, elapsed_ff};
   assign bw_diff   = {1'b0, limit_ff} - {1'b0, used_ff};
   assign trem      = time_diff[32] ? 32'd0 : time_diff[31:0];
   assign brem      = (limit_ff == 32'd0) ? UNLIMITED_BW :
                      (bw_diff[32] ? 32'd0 : bw_diff[31:0]);
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   assign removed_wide = {5'b0, removed_ff};
   assign entry_wide   = {5'b0, entry_in};

   // ---------------- controller ----------------
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      ip_in        = ip_ff;
      value_in     = value_ff;
      now_in       = now_ff;
      elapsed_in   = elapsed_ff;
      life_in      = life_ff;
      used_in      = used_ff;
      entry_in     = entry_ff;
      any_match_in = any_match_ff;
      any_free_in  = any_free_ff;
      hit_in       = hit_ff;
      full_in      = full_ff;
      removed_in   = removed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in  = func_type'(req_tuser);
               ip_in    = req_tdata[31:0];
               value_in = req_tdata[63:32];
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            any_match_in = links[ENTRIES].match_seen;
            any_free_in  = links[ENTRIES].free_seen;
            state_in     = ST_APPLY;
         end
         ST_APPLY: begin
            hit_in     = 1'b0;
            full_in    = 1'b0;
            removed_in = '0;
            case (func_ff)
               FUNC_TICK: begin
                  now_in     = now_ff + 32'd1;
                  elapsed_in = elapsed_ff + 32'd1;
               end
               FUNC_ADD: begin
                  if (any_match_ff)     hit_in   = 1'b1;
                  else if (any_free_ff) entry_in = entry_ff + CNT_W'(1);
                  else                  full_in  = 1'b1;
               end
               FUNC_REMOVE: begin
                  if (any_match_ff) begin
                     hit_in   = 1'b1;
                     entry_in = entry_ff - CNT_W'(1);
                  end
               end
               FUNC_REMOVE_ALL: begin
                  removed_in = entry_ff;
                  entry_in   = '0;
               end
               FUNC_LOOKUP: begin
                  hit_in = any_match_ff;
               end
               FUNC_USAGE: begin
                  elapsed_in = '0;
                  used_in    = used_sum[32] ? 32'hFFFF_FFFF : used_sum[31:0];
               end
               FUNC_SET_LIFETIME: begin
                  life_in    = value_ff;
                  elapsed_in = '0;
               end
               FUNC_SWEEP: begin
                  removed_in = drop_count;
               end
               default: begin
                  hit_in = 1'b0;
               end
            endcase
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            // hold until the response register can take the result
            if (rsp_free) begin
               if (func_ff == FUNC_SWEEP) entry_in = entry_ff - removed_ff;
               rsp_data_in = {2'b00,
                              (trem != 32'd0) && (brem != 32'd0),
                              trem == 32'd0,
                              brem,
                              trem,
                              entry_wide[4:0],
                              removed_wide[4:0],
                              full_ff,
                              hit_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         elapsed_ff   <= '0;
         life_ff      <= '0;
         used_ff      <= '0;
         entry_ff     <= '0;
         any_match_ff <= 1'b0;
         any_free_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         full_ff      <= 1'b0;
         removed_ff   <= '0;
         limit_ff     <= '0;
         perm_life_ff <= 16'd300;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         elapsed_ff   <= elapsed_in;
         life_ff      <= life_in;
         used_ff      <= used_in;
         entry_ff     <= entry_in;
         any_match_ff <= any_match_in;
         any_free_ff  <= any_free_in;
         hit_ff       <= hit_in;
         full_ff      <= full_in;
         removed_ff   <= removed_in;
         limit_ff     <= limit_in;
         perm_life_ff <= perm_life_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      ip_ff       <= ip_in;
      value_ff    <= value_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------- assertions ----------------
   `RPT_ASSERT_NEXT(a_accept_to_look, clock, reset, req_tvalid && req_tready,
      state_ff == ST_LOOK, "accepted request did not start a lookup")
   `RPT_ASSERT_IMPLY(a_count_tracks_cells, clock, reset, state_ff == ST_IDLE,
      $countones(valid_vec) == int'(entry_ff), "entry count disagrees with cells")
   `RPT_ASSERT_IMPLY(a_peer_unique, clock, reset, state_ff == ST_APPLY,
      $onehot0(match_vec), "peer address held by more than one cell")
   `RPT_ASSERT_NEXT(a_report_loads_rsp, clock, reset,
      state_ff == ST_REPORT && rsp_free, rsp_valid_ff && state_ff == ST_IDLE,
      "status cycle did not load the response")

endmodule
